### rtl/core/tcbf_pkg.sv
// ----------------------------------------------------------------------------
// tcbf_pkg: shared types and constants for the touch channel baseline filter
// Field widths, saturation limits, filter defaults and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int DELTA_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int ACQ_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int BASE_ACC_W  = 32;

    localparam int NOISE_SHIFT_DEF        = 3;
    localparam int BASELINE_SHIFT_DEF     = 16;
    localparam int ACQUIRE_SHIFT_DEF      = 8;
    localparam int GAIN_FRACTION_BITS_DEF = 14;

    localparam logic [LEVEL_W-1:0]        LEVEL_MAX       = 16'hFFFF;
    localparam logic signed [DELTA_W-1:0] DELTA_MAX       = 16'sh7FFF;
    localparam logic signed [GAIN_W-1:0]  GAIN_UNITY      = 16'sh4000;
    localparam logic [ACQ_W-1:0]          ACQUIRE_DEFAULT = 16'd750;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INVERT   = 2'd0,
        CFG_GAIN_EN  = 2'd1,
        CFG_GAIN     = 2'd2,
        CFG_ACQ_LEN  = 2'd3
    } t_cfg_index;

endpackage

`default_nettype wire

### rtl/core/tcbf_if.sv
// ----------------------------------------------------------------------------
// tcbf_if: valid/ready channels of the touch channel baseline filter
// One channel for raw samples, one for filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcbf_sample_if;
    logic                              valid;
    logic                              ready;
    logic [tcbf_pkg::SAMPLE_W-1:0]     sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tcbf_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [tcbf_pkg::DELTA_W-1:0] delta;
    logic [tcbf_pkg::LEVEL_W-1:0]      level;
    logic                              acquiring;

    modport source (output valid, output delta, output level, output acquiring,
                    input ready);
    modport sink   (input valid, input delta, input level, input acquiring,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/touch_channel_baseline_filter_top.sv
// ----------------------------------------------------------------------------
// touch_channel_baseline_filter_top: per-channel capacitive touch filtering
// Stages A, B and C register each accepted sample in turn; C drives the output.
// Throughput: one item per cycle while the output accepts; the noise and baseline
//   IIR states are single registers updated once per item as it enters the middle
//   stage. A new item can be taken while a finished result waits at the output
//   if stage A or B is empty. Reset (synchronous, active low) empties the
//   pipeline, clears both filter states to uninitialized and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_channel_baseline_filter_top #(
    parameter int NOISE_SHIFT        = tcbf_pkg::NOISE_SHIFT_DEF,
    parameter int BASELINE_SHIFT     = tcbf_pkg::BASELINE_SHIFT_DEF,
    parameter int ACQUIRE_SHIFT      = tcbf_pkg::ACQUIRE_SHIFT_DEF,
    parameter int GAIN_FRACTION_BITS = tcbf_pkg::GAIN_FRACTION_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [tcbf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire [tcbf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    tcbf_sample_if.sink                         i_sample_ch,
    tcbf_result_if.source                       o_result_ch
);

    // Width of the baseline after scaling to the level format, and of the
    // signed difference between the two (one bit for headroom, one for sign).
    localparam int LEVEL_SH = BASELINE_SHIFT - NOISE_SHIFT;
    localparam int BASE_W   = tcbf_pkg::BASE_ACC_W - LEVEL_SH;
    localparam int WIDE_W   = (BASE_W > tcbf_pkg::LEVEL_W) ? BASE_W : tcbf_pkg::LEVEL_W;
    localparam int DIFF_W   = WIDE_W + 2;
    localparam int PROD_W   = DIFF_W + tcbf_pkg::GAIN_W;
    localparam int SEED_W   = tcbf_pkg::SAMPLE_W + NOISE_SHIFT;

    // ------------------------------------------------------------------
    // Configuration registers; a length write reloads the counter directly
    // ------------------------------------------------------------------
    logic                                   r_invert;
    logic                                   r_gain_en;
    logic signed [tcbf_pkg::GAIN_W-1:0]     r_gain;

    // ------------------------------------------------------------------
    // Filter state
    // ------------------------------------------------------------------
    logic [tcbf_pkg::LEVEL_W-1:0]           r_noise;
    logic [tcbf_pkg::BASE_ACC_W-1:0]        r_base;
    logic [tcbf_pkg::ACQ_W-1:0]             r_acq_left;

    // ------------------------------------------------------------------
    // Pipeline registers: A holds the raw sample, B the unscaled delta,
    // C the finished result.
    // ------------------------------------------------------------------
    logic                                   r_a_valid;
    logic [tcbf_pkg::SAMPLE_W-1:0]          r_a_sample;
    logic                                   r_b_valid;
    logic signed [DIFF_W-1:0]               r_b_diff;
    logic [tcbf_pkg::LEVEL_W-1:0]           r_b_level;
    logic                                   r_b_acq;
    logic                                   r_c_valid;
    logic signed [tcbf_pkg::DELTA_W-1:0]    r_c_delta;
    logic [tcbf_pkg::LEVEL_W-1:0]           r_c_level;
    logic                                   r_c_acq;

    // Stage enables: a stage loads when it is empty or its item moves on.
    logic w_en_a, w_en_b, w_en_c;
    assign w_en_c = !r_c_valid || o_result_ch.ready;
    assign w_en_b = !r_b_valid || w_en_c;
    assign w_en_a = !r_a_valid || w_en_b;
    assign i_sample_ch.ready = w_en_a;

    wire w_update = w_en_b && r_a_valid;

    // ------------------------------------------------------------------
    // Noise IIR: seed from the sample when uninitialized, saturate at max
    // ------------------------------------------------------------------
    logic [SEED_W-1:0]                  w_seed_wide;
    logic [tcbf_pkg::LEVEL_W-1:0]       w_noise_seed;
    logic [tcbf_pkg::LEVEL_W-1:0]       w_noise_cur;
    logic [tcbf_pkg::LEVEL_W:0]         w_noise_sum;
    logic [tcbf_pkg::LEVEL_W-1:0]       n_noise;

    assign w_seed_wide  = {r_a_sample, {NOISE_SHIFT{1'b0}}};
    assign w_noise_seed = (|w_seed_wide[SEED_W-1:tcbf_pkg::LEVEL_W]) ?
                          tcbf_pkg::LEVEL_MAX : w_seed_wide[tcbf_pkg::LEVEL_W-1:0];
    assign w_noise_cur  = (r_noise == '0) ? w_noise_seed : r_noise;
    assign w_noise_sum  = {1'b0, w_noise_cur} - {1'b0, w_noise_cur >> NOISE_SHIFT}
                        + {1'b0, r_a_sample};
    assign n_noise      = w_noise_sum[tcbf_pkg::LEVEL_W] ?
                          tcbf_pkg::LEVEL_MAX : w_noise_sum[tcbf_pkg::LEVEL_W-1:0];

    // ------------------------------------------------------------------
    // Baseline IIR: fast alpha while acquisition samples remain; wraps
    // ------------------------------------------------------------------
    logic [tcbf_pkg::BASE_ACC_W-1:0]    w_sample_ext;
    logic [tcbf_pkg::BASE_ACC_W-1:0]    w_base_cur;
    logic [tcbf_pkg::BASE_ACC_W-1:0]    n_base;
    logic [tcbf_pkg::ACQ_W-1:0]         n_acq_left;
    logic                               w_acq_active;

    assign w_sample_ext = {{(tcbf_pkg::BASE_ACC_W - tcbf_pkg::SAMPLE_W){1'b0}}, r_a_sample};
    assign w_base_cur   = (r_base == '0) ? (w_sample_ext << BASELINE_SHIFT) : r_base;
    assign w_acq_active = (r_acq_left != '0);

    always_comb begin
        if (w_acq_active) begin
            n_base     = w_base_cur - (w_base_cur >> ACQUIRE_SHIFT)
                       + (w_sample_ext << (BASELINE_SHIFT - ACQUIRE_SHIFT));
            n_acq_left = r_acq_left - tcbf_pkg::ACQ_W'(1);
        end else begin
            n_base     = w_base_cur - (w_base_cur >> BASELINE_SHIFT) + w_sample_ext;
            n_acq_left = r_acq_left;
        end
    end

    // Difference between level and scaled baseline, polarity applied.
    logic signed [DIFF_W-1:0] w_level_s, w_base_s, n_diff;
    assign w_level_s = $signed({{(DIFF_W - tcbf_pkg::LEVEL_W){1'b0}}, n_noise});
    assign w_base_s  = $signed({{(DIFF_W - BASE_W){1'b0}},
                                n_base[tcbf_pkg::BASE_ACC_W-1:LEVEL_SH]});
    assign n_diff    = r_invert ? (w_base_s - w_level_s) : (w_level_s - w_base_s);

    // ------------------------------------------------------------------
    // Gain and saturation on the delta held in stage B
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]               w_prod;
    logic signed [PROD_W-1:0]               w_scaled;
    logic signed [tcbf_pkg::DELTA_W-1:0]    n_delta;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(tcbf_pkg::DELTA_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI;

    assign w_prod   = PROD_W'(r_b_diff) * PROD_W'(r_gain);
    // Arithmetic shift floors toward minus infinity.
    assign w_scaled = r_gain_en ? (w_prod >>> GAIN_FRACTION_BITS) : PROD_W'(r_b_diff);

    always_comb begin
        if (w_scaled > SAT_HI) begin
            n_delta = tcbf_pkg::DELTA_MAX;
        end else if (w_scaled < SAT_LO) begin
            n_delta = -tcbf_pkg::DELTA_MAX;
        end else begin
            n_delta = w_scaled[tcbf_pkg::DELTA_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Configuration and filter state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert   <= 1'b0;
            r_gain_en  <= 1'b0;
            r_gain     <= tcbf_pkg::GAIN_UNITY;
            r_noise    <= '0;
            r_base     <= '0;
            r_acq_left <= tcbf_pkg::ACQUIRE_DEFAULT;
        end else begin
            // Advance the filters once per item entering stage B.
            if (w_update) begin
                r_noise    <= n_noise;
                r_base     <= n_base;
                r_acq_left <= n_acq_left;
            end
            if (i_cfg_we) begin
                case (tcbf_pkg::t_cfg_index'(i_cfg_index))
                    tcbf_pkg::CFG_INVERT:  r_invert  <= i_cfg_data[0];
                    tcbf_pkg::CFG_GAIN_EN: r_gain_en <= i_cfg_data[0];
                    tcbf_pkg::CFG_GAIN:    r_gain    <= $signed(i_cfg_data[tcbf_pkg::GAIN_W-1:0]);
                    tcbf_pkg::CFG_ACQ_LEN: begin
                        // Restart fast acquisition with the new length.
                        r_acq_left <= i_cfg_data[tcbf_pkg::ACQ_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_en_a) r_a_valid <= i_sample_ch.valid;
            if (w_en_b) r_b_valid <= r_a_valid;
            if (w_en_c) r_c_valid <= r_b_valid;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_en_a && i_sample_ch.valid) begin
            r_a_sample <= i_sample_ch.sample;
        end
        if (w_update) begin
            r_b_diff  <= n_diff;
            r_b_level <= n_noise;
            r_b_acq   <= (n_acq_left != '0);
        end
        if (w_en_c && r_b_valid) begin
            r_c_delta <= n_delta;
            r_c_level <= r_b_level;
            r_c_acq   <= r_b_acq;
        end
    end

    assign o_result_ch.valid     = r_c_valid;
    assign o_result_ch.delta     = r_c_delta;
    assign o_result_ch.level     = r_c_level;
    assign o_result_ch.acquiring = r_c_acq;

endmodule

`default_nettype wire

### rtl/core/tcbf_checker.sv
// ----------------------------------------------------------------------------
// tcbf_checker: port-level checks for the touch channel baseline filter
// Watches the result channel and the decoupling of input from output.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbf_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_ready,
    input  wire                                 i_out_valid,
    input  wire                                 i_out_ready,
    input  wire signed [tcbf_pkg::DELTA_W-1:0]  i_out_delta,
    input  wire [tcbf_pkg::LEVEL_W-1:0]         i_out_level
);

    // Hold a stalled result.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_delta) && $stable(i_out_level))
        else $error("stalled result changed");

    // Saturation is symmetric: the most negative code never appears.
    a_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_delta != 16'sh8000))
        else $error("delta outside symmetric range");

    // Reset empties the output stage.
    a_rst : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With the output stage empty every stage can advance, so input is taken.
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

endmodule

bind touch_channel_baseline_filter_top tcbf_checker u_tcbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample_ch.ready),
    .i_out_valid (o_result_ch.valid),
    .i_out_ready (o_result_ch.ready),
    .i_out_delta (o_result_ch.delta),
    .i_out_level (o_result_ch.level)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the touch channel baseline filter
// Drives raw sensor counts through the sample channel under random source and
// sink gaps, mirrors both IIR filters, the acquisition counter and the delta
// arithmetic in a local model, and checks every result item field by field.
// ----------------------------------------------------------------------------

module testbench;

    import tcbf_pkg::*;

    // Filter shifts as built into the block under test.
    localparam int NSH = NOISE_SHIFT_DEF;
    localparam int BSH = BASELINE_SHIFT_DEF;
    localparam int ASH = ACQUIRE_SHIFT_DEF;
    localparam int GFB = GAIN_FRACTION_BITS_DEF;

    // Cycles to let pass after the last result before touching a register:
    // three pipeline stages plus margin.
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1200000;
    localparam int RANDOM_PHASES = 22;
    localparam int PHASE_ITEMS   = 82;
    localparam int MAX_REPORTS   = 20;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [LEVEL_W-1:0]        level;
        logic                      acquiring;
    } t_filt_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tcbf_sample_if sample_ch();
    tcbf_result_if result_ch();

    touch_channel_baseline_filter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch)
    );

    // Local copy of the register file and the filter state.
    logic                      cfg_invert;
    logic                      cfg_gain_en;
    logic signed [GAIN_W-1:0]  cfg_gain;
    logic [LEVEL_W-1:0]        noise_st;
    logic [BASE_ACC_W-1:0]     base_st;
    logic [ACQ_W-1:0]          acq_st;

    t_filt_result expected_q[$];

    int  errors = 0;
    int  samples_sent = 0;
    int  results_checked = 0;
    int  reg_writes = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    bit  gaps_on = 1'b1;

    // Clock: 4 ns period.
    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: end the run once the total cycle count passes the limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time, expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Restore the register defaults and mark both filters uninitialized.
    function automatic void reset_filter_model();
        cfg_invert  = 1'b0;
        cfg_gain_en = 1'b0;
        cfg_gain    = GAIN_UNITY;
        noise_st    = '0;
        base_st     = '0;
        acq_st      = ACQUIRE_DEFAULT;
    endfunction

    // Advance both filters by one sample and work out the result item.
    function automatic t_filt_result advance_filter(input logic [SAMPLE_W-1:0] s);
        logic [31:0]  v;
        logic [31:0]  b;
        longint       lvl;
        longint       base;
        longint       dlt;
        t_filt_result r;
        // Seed a filter whose state is still zero; the noise seed saturates.
        if (noise_st == '0) begin
            v = {16'd0, s} << NSH;
            noise_st = (v > 32'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
        end
        if (base_st == '0)
            base_st = {16'd0, s} << BSH;
        v = {16'd0, noise_st};
        v = v - (v >> NSH) + {16'd0, s};
        noise_st = (v > 32'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
        // Fast alpha while acquisition samples remain, slow alpha after.
        b = base_st;
        if (acq_st == '0) begin
            b = b - (b >> BSH) + {16'd0, s};
        end else begin
            acq_st = acq_st - 1'b1;
            b = b - (b >> ASH) + ({16'd0, s} << (BSH - ASH));
        end
        base_st = b;
        lvl  = longint'({48'd0, noise_st});
        base = longint'({32'd0, base_st >> (BSH - NSH)});
        dlt  = cfg_invert ? (base - lvl) : (lvl - base);
        // Exact product, then an arithmetic shift: rounds toward minus infinity.
        if (cfg_gain_en)
            dlt = (dlt * longint'(cfg_gain)) >>> GFB;
        if (dlt > longint'(DELTA_MAX))
            dlt = longint'(DELTA_MAX);
        else if (dlt < -longint'(DELTA_MAX))
            dlt = -longint'(DELTA_MAX);
        r.delta     = dlt[DELTA_W-1:0];
        r.level     = noise_st;
        r.acquiring = (acq_st != '0);
        return r;
    endfunction

    // Gap length for either side: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Offer one sample and hold it until accepted. Valid stays high on return
    // so that a following item can go out back to back.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        expected_q.push_back(advance_filter(s));
        samples_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline empty.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; only called once the block is idle.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_INVERT:  cfg_invert  = data[0];
            CFG_GAIN_EN: cfg_gain_en = data[0];
            CFG_GAIN:    cfg_gain    = data;
            CFG_ACQ_LEN: begin
                // A new length also restarts fast acquisition.
                acq_st      = data;
            end
            default: ;
        endcase
        reg_writes++;
        // Return with the write enable low so that writes do not run back to back.
        @(posedge i_clk);
    endtask

    // Compare one accepted result item with the oldest expectation.
    task automatic check_result();
        t_filt_result want;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: unexpected result, expected none, actual delta %0d level %0d",
                         $time, $signed(result_ch.delta), result_ch.level);
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (result_ch.delta !== want.delta) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: delta mismatch, expected %0d, actual %0d",
                         $time, $signed(want.delta), $signed(result_ch.delta));
        end
        if (result_ch.level !== want.level) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: level mismatch, expected %0d, actual %0d",
                         $time, want.level, result_ch.level);
        end
        if (result_ch.acquiring !== want.acquiring) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: acquiring mismatch, expected %0b, actual %0b",
                         $time, want.acquiring, result_ch.acquiring);
        end
    endtask

    // Result sink: check each accepted item and drive ready with random gaps.
    // A hold request stalls the output for a long stretch, counted here.
    initial begin : result_sink
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                check_result();
                gap_left = pick_gap();
            end
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request <= 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                // Stall now and then even with nothing waiting.
                if ($urandom_range(0, 15) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // Seeding from the first samples: a zero sample leaves both filters
    // uninitialized, a full-scale seed saturates the noise state, then the
    // level decays from the top under zero input.
    task automatic test_seeding();
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h0001);
    endtask

    // Inversion and the gain multiply at both coefficient extremes, then zero and
    // unity. Upper data bits of the one-bit registers are set and ignored.
    task automatic test_polarity_gain();
        settle();
        write_reg(CFG_INVERT, 16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        settle();
        write_reg(CFG_INVERT, 16'hFFFE);
        write_reg(CFG_GAIN_EN, 16'h0001);
        write_reg(CFG_GAIN, 16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        settle();
        write_reg(CFG_GAIN, 16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        settle();
        write_reg(CFG_GAIN, 16'h0000);
        send_sample(16'hFFFF);
        settle();
        write_reg(CFG_GAIN, 16'h4000);
        send_sample(16'h4000);
    endtask

    // Acquisition length writes reload the counter: none, one sample (runs
    // out on the first step) and the longest length.
    task automatic test_acquire_reload();
        settle();
        write_reg(CFG_GAIN_EN, 16'h0000);
        write_reg(CFG_ACQ_LEN, 16'h0000);
        send_sample(16'h1234);
        send_sample(16'hEDCB);
        settle();
        write_reg(CFG_ACQ_LEN, 16'h0001);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        settle();
        write_reg(CFG_ACQ_LEN, 16'hFFFF);
        send_sample(16'h0F0F);
        send_sample(16'hF0F0);
    endtask

    // Output held off for a long stretch while samples keep coming with no
    // source gaps: the pipeline fills and stalls the input.
    task automatic test_backpressure();
        int k;
        settle();
        gaps_on <= 1'b0;
        hold_request <= HOLD_CYCLES;
        @(posedge i_clk);
        for (k = 0; k < 50; k++)
            send_sample(16'(9000 + $urandom_range(0, 400)));
        settle();
        gaps_on <= 1'b1;
    endtask

    // Phases of touch-like traffic under random register settings: a rest
    // level with small noise and occasional touch bumps, mixed with
    // full-range noise samples.
    task automatic test_tracking();
        int p;
        int k;
        int rest;
        int bump;
        int touch_left;
        int s;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            write_reg(CFG_INVERT, 16'($urandom_range(0, 65535)));
            write_reg(CFG_GAIN_EN, 16'($urandom_range(0, 65535)));
            case ($urandom_range(0, 4))
                0: write_reg(CFG_GAIN, 16'h8000);
                1: write_reg(CFG_GAIN, 16'h7FFF);
                2: write_reg(CFG_GAIN, 16'h4000);
                3: write_reg(CFG_GAIN, 16'h0000);
                default: write_reg(CFG_GAIN, 16'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_ACQ_LEN, 16'h0000);
                1: write_reg(CFG_ACQ_LEN, 16'h0001);
                2: write_reg(CFG_ACQ_LEN, 16'($urandom_range(2, 120)));
                3: write_reg(CFG_ACQ_LEN, 16'hFFFF);
                4: write_reg(CFG_ACQ_LEN, ACQUIRE_DEFAULT);
                default: ;  // keep the running count
            endcase
            // One phase in four runs with no gaps on either side.
            gaps_on <= ($urandom_range(0, 3) != 0);
            rest = $urandom_range(200, 60000);
            bump = 0;
            touch_left = 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < 2) begin
                    s = $urandom_range(0, 65535);
                end else begin
                    if (touch_left > 0) begin
                        touch_left--;
                    end else begin
                        bump = 0;
                        if ($urandom_range(0, 19) == 0) begin
                            touch_left = $urandom_range(5, 30);
                            bump = $urandom_range(50, 5000);
                        end
                    end
                    s = rest + bump + $urandom_range(0, 40) - 20;
                    if (s < 0)
                        s = 0;
                    if (s > 65535)
                        s = 65535;
                end
                send_sample(16'(s));
            end
        end
        settle();
        gaps_on <= 1'b1;
    endtask

    // Main sequence: reset once, run the tests in turn, then report.
    initial begin : main_sequence
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_INVERT;
        cfg_data  <= '0;
        reset_filter_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_seeding();
        test_polarity_gain();
        test_acquire_reload();
        test_backpressure();
        test_tracking();

        // Drain: nothing may remain expected, then allow the pipeline latency.
        settle();
        $display("Summary: %0d samples sent, %0d results checked, %0d register writes",
                 samples_sent, results_checked, reg_writes);
        $display("Summary: seeding, polarity, gain extremes, acquisition reloads, %0d-cycle stall",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
